FILE: rtl/tqg_pkg.sv
// ----------------------------------------------------------------------------
// tqg_pkg
// Shared types, widths and arithmetic helpers for the two-qubit gate core.
// ----------------------------------------------------------------------------
package tqg_pkg;

    localparam int AMP_W  = 16;
    localparam int WORD_W = 2 * AMP_W;
    localparam int PROD_W = 2 * AMP_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - 14;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_GATE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [1:0] row;
    } t_mac_ctl;

    // Q6.29 sum to Q1.15: add half an LSB, floor, saturate.
    function automatic logic signed [AMP_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] biased;
        logic signed [RND_W-1:0] v;
        biased = acc + ACC_W'(8192);
        v      = biased[ACC_W-1:14];
        if (v > RND_W'(32767)) begin
            round_sat = 16'sh7FFF;
        end else if (v < -RND_W'(32768)) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = v[AMP_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/two_qubit_gate_state_vector_core.sv
// ----------------------------------------------------------------------------
// two_qubit_gate_state_vector_core
// State vector of 2^QUBITS Q1.15 complex amplitudes with a configurable
// 4x4 complex gate applied to neighboring qubit pairs.
// ----------------------------------------------------------------------------
// The amplitudes sit in one memory (one write and one registered read port);
// qubit 0 is the address MSB. A gate beat sweeps the memory in groups of
// four amplitudes: four reads, the sixteen gate entries through the single
// complex multiplier (one gate entry per cycle), accumulate and rounding
// drain, and four writes back. Load every amplitude before applying a gate;
// gate registers are to be written by the user only while the core is idle;
// the core itself does not enforce this.
module two_qubit_gate_state_vector_core #(
    parameter int QUBITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_index,
    input  logic [3:0]  i_site,
    input  logic signed [15:0] i_amp_re,
    input  logic signed [15:0] i_amp_im,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_done_kind,
    output logic signed [15:0] o_read_re,
    output logic signed [15:0] o_read_im,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int AW    = QUBITS;
    localparam int DEPTH = 2 ** QUBITS;
    localparam logic [63:0] GATE_RST [8] = '{
        64'd16384, 64'd0, 64'd16384 << 32, 64'd0,
        64'd0, 64'd16384, 64'd0, 64'd16384 << 32
    };

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_GRD, S_GMAC, S_GDRAIN, S_GWR
    } t_state;

    t_state                          r_state;
    logic [3:0]                      r_cnt;
    logic [AW-1:0]                   r_n, r_hi, r_lo;
    logic [63:0]                     r_gate [8];
    logic [tqg_pkg::WORD_W-1:0]      r_mem  [DEPTH];
    logic [tqg_pkg::WORD_W-1:0]      r_amp  [4];
    logic [tqg_pkg::WORD_W-1:0]      r_nw   [4];
    logic                            r_out_valid;
    logic [1:0]                      r_out_kind;
    logic signed [15:0]              r_out_re, r_out_im;

    logic                            in_acc;
    logic                            out_set;
    logic [AW-1:0]                   idx, pair, grp_addr, n_n, n_hi, n_lo;
    logic [4:0]                      site5, hi_sh;
    logic                            last_grp;
    logic                            mem_we, mem_re;
    logic [AW-1:0]                   mem_wa, mem_ra;
    logic [tqg_pkg::WORD_W-1:0]      mem_wd;
    logic [1:0]                      rd_slot;
    logic [63:0]                     gsel;
    logic signed [15:0]              g_re, g_im;
    logic [tqg_pkg::WORD_W-1:0]      a_sel;
    tqg_pkg::t_mac_ctl               mac_ctl;
    logic                            res_valid;
    logic [1:0]                      res_row;
    logic [tqg_pkg::WORD_W-1:0]      res_word;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx        = AW'(i_index);

    assign site5 = {1'b0, i_site};
    assign hi_sh = 5'(QUBITS - 1) - site5;
    always_comb begin
        if (site5 < 5'(QUBITS - 1)) begin
            n_hi = AW'(1) << hi_sh;
            n_lo = AW'(1) << (hi_sh - 5'd1);
        end else begin
            n_hi = AW'(1);
            n_lo = AW'(1) << (AW - 1);
        end
    end

    assign pair     = r_hi | r_lo;
    assign last_grp = ((r_n | pair) == {AW{1'b1}});
    assign n_n      = ((r_n | pair) + AW'(1)) & ~pair;
    assign grp_addr = r_n | (r_cnt[1] ? r_hi : '0) | (r_cnt[0] ? r_lo : '0);

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = grp_addr;
        mem_wd  = r_nw[r_cnt[1:0]];
        mem_re  = 1'b0;
        mem_ra  = grp_addr;
        rd_slot = r_cnt[1:0];
        if (r_state == S_IDLE) begin
            mem_wa  = idx;
            mem_wd  = {i_amp_im, i_amp_re};
            mem_ra  = idx;
            rd_slot = 2'd0;
            mem_we  = in_acc && (i_kind == tqg_pkg::KIND_WRITE);
            mem_re  = in_acc && (i_kind == tqg_pkg::KIND_READ);
        end else if (r_state == S_GRD) begin
            mem_re = 1'b1;
        end else if (r_state == S_GWR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_amp[rd_slot] <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= GATE_RST;
        end else if (i_cfg_we) begin
            r_gate[i_cfg_idx] <= i_cfg_data;
        end
    end

    // row = cnt[3:2], column = cnt[1:0]
    assign gsel  = r_gate[{r_cnt[3:2], r_cnt[1]}];
    assign g_re  = r_cnt[0] ? gsel[47:32] : gsel[15:0];
    assign g_im  = r_cnt[0] ? gsel[63:48] : gsel[31:16];
    assign a_sel = r_amp[r_cnt[1:0]];

    always_comb begin
        mac_ctl.valid = (r_state == S_GMAC);
        mac_ctl.first = (r_cnt[1:0] == 2'd0);
        mac_ctl.last  = (r_cnt[1:0] == 2'd3);
        mac_ctl.row   = r_cnt[3:2];
    end

    tqg_cmac u_cmac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_g_re      (g_re),
        .i_g_im      (g_im),
        .i_a_re      (a_sel[15:0]),
        .i_a_im      (a_sel[31:16]),
        .o_res_valid (res_valid),
        .o_res_row   (res_row),
        .o_res_word  (res_word)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_nw[res_row] <= res_word;
        end
    end

    assign out_set = ((r_state == S_IDLE) && in_acc && (i_kind == tqg_pkg::KIND_WRITE))
                  || (r_state == S_RD)
                  || ((r_state == S_GWR) && (r_cnt == 4'd3) && last_grp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            tqg_pkg::KIND_WRITE: begin
                                r_out_kind  <= tqg_pkg::KIND_WRITE;
                                r_out_re    <= '0;
                                r_out_im    <= '0;
                            end
                            tqg_pkg::KIND_READ: begin
                                r_state <= S_RD;
                            end
                            tqg_pkg::KIND_GATE: begin
                                r_hi    <= n_hi;
                                r_lo    <= n_lo;
                                r_n     <= '0;
                                r_cnt   <= '0;
                                r_state <= S_GRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_out_kind  <= tqg_pkg::KIND_READ;
                    r_out_re    <= r_amp[0][15:0];
                    r_out_im    <= r_amp[0][31:16];
                    r_state     <= S_IDLE;
                end
                S_GRD: begin
                    if (r_cnt == 4'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_GMAC;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_GMAC: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_GDRAIN;
                    end
                end
                S_GDRAIN: begin
                    if (r_cnt == 4'd1) begin
                        r_cnt   <= '0;
                        r_state <= S_GWR;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_GWR: begin
                    if (r_cnt == 4'd3) begin
                        r_cnt <= '0;
                        if (last_grp) begin
                            r_out_kind  <= tqg_pkg::KIND_GATE;
                            r_out_re    <= '0;
                            r_out_im    <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_n     <= n_n;
                            r_state <= S_GRD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_done_kind = r_out_kind;
    assign o_read_re   = r_out_re;
    assign o_read_im   = r_out_im;

`ifndef SYNTH
    a_pair_two_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRD || r_state == S_GMAC || r_state == S_GWR)
        |-> ($countones(pair) == 2))
        else $error("gate pair mask does not hold two qubits");

    a_group_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRD || r_state == S_GWR) |-> ((r_n & pair) == '0))
        else $error("group base has a pair bit set");

    a_mem_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_GWR || (r_state == S_IDLE && in_acc)))
        else $error("memory write outside write beat or write-back");

    a_mac_result_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_state == S_GMAC || r_state == S_GDRAIN || r_state == S_GWR))
        else $error("gate row result outside multiply phase");
`endif

endmodule

FILE: rtl/tqg_cmac.sv
// ----------------------------------------------------------------------------
// tqg_cmac
// Complex multiply-accumulate: one complex product per cycle, four products
// summed per gate row, then rounded and saturated to a packed amplitude word.
// ----------------------------------------------------------------------------
module tqg_cmac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tqg_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [tqg_pkg::AMP_W-1:0]  i_g_re,
    input  logic signed [tqg_pkg::AMP_W-1:0]  i_g_im,
    input  logic signed [tqg_pkg::AMP_W-1:0]  i_a_re,
    input  logic signed [tqg_pkg::AMP_W-1:0]  i_a_im,
    output logic                              o_res_valid,
    output logic [1:0]                        o_res_row,
    output logic [tqg_pkg::WORD_W-1:0]        o_res_word
);

    logic signed [2*tqg_pkg::AMP_W-1:0] m_rr, m_ii, m_ri, m_ir;
    logic signed [tqg_pkg::PROD_W-1:0]  n_prod_re, n_prod_im;
    logic signed [tqg_pkg::PROD_W-1:0]  r_prod_re, r_prod_im;
    logic signed [tqg_pkg::ACC_W-1:0]   r_acc_re, r_acc_im;
    tqg_pkg::t_mac_ctl                  r_p_ctl;
    logic                               r_a_last;
    logic [1:0]                         r_a_row;
    logic                               r_res_valid;
    logic [1:0]                         r_res_row;
    logic [tqg_pkg::WORD_W-1:0]         r_res_word;

    assign m_rr = i_g_re * i_a_re;
    assign m_ii = i_g_im * i_a_im;
    assign m_ri = i_g_re * i_a_im;
    assign m_ir = i_g_im * i_a_re;

    assign n_prod_re = tqg_pkg::PROD_W'(m_rr) - tqg_pkg::PROD_W'(m_ii);
    assign n_prod_im = tqg_pkg::PROD_W'(m_ri) + tqg_pkg::PROD_W'(m_ir);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl     <= '0;
            r_a_last    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_p_ctl     <= i_ctl;
            r_a_last    <= r_p_ctl.valid && r_p_ctl.last;
            r_res_valid <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_re <= n_prod_re;
        r_prod_im <= n_prod_im;
        r_a_row   <= r_p_ctl.row;
        r_res_row <= r_a_row;
        if (r_p_ctl.valid) begin
            r_acc_re <= (r_p_ctl.first ? '0 : r_acc_re) + tqg_pkg::ACC_W'(r_prod_re);
            r_acc_im <= (r_p_ctl.first ? '0 : r_acc_im) + tqg_pkg::ACC_W'(r_prod_im);
        end
        if (r_a_last) begin
            r_res_word <= {tqg_pkg::round_sat(r_acc_im), tqg_pkg::round_sat(r_acc_re)};
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_row   = r_res_row;
    assign o_res_word  = r_res_word;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for two_qubit_gate_state_vector_core: it loads the
// state vector, reads it back, and applies two-qubit gates at a set of sites
// and at random sites under several gate settings. A bit-exact predictor
// mirrors the store and the gate registers. Results are checked in order,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUBITS       = 10;
    localparam int DEPTH        = 1 << QUBITS;
    localparam int NUM_GATE_REG = 8;
    localparam int STALL_LIMIT  = 40000;
    localparam int SETTLE       = 20;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] REG_ROW0_C01 = 3'd0;
    localparam logic [2:0] REG_ROW0_C23 = 3'd1;
    localparam logic [2:0] REG_ROW1_C01 = 3'd2;
    localparam logic [2:0] REG_ROW1_C23 = 3'd3;
    localparam logic [2:0] REG_ROW2_C01 = 3'd4;
    localparam logic [2:0] REG_ROW2_C23 = 3'd5;
    localparam logic [2:0] REG_ROW3_C01 = 3'd6;
    localparam logic [2:0] REG_ROW3_C23 = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] re;
        logic [15:0] im;
    } t_done;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [9:0]  i_index;
    logic [3:0]  i_site;
    logic signed [15:0] i_amp_re;
    logic signed [15:0] i_amp_im;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_done_kind;
    logic signed [15:0] o_read_re;
    logic signed [15:0] o_read_im;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    logic [31:0] amp_model [DEPTH];
    logic        amp_loaded [DEPTH];
    logic [63:0] gate_cfg [NUM_GATE_REG];
    t_done       pending_done [$];

    int errors;
    int idle_cycles;
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_burst;
    int rx_hold;

    two_qubit_gate_state_vector_core #(.QUBITS(QUBITS)) uut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic longint gate_entry(input int r, input int c, input int p);
        logic [63:0]        reg_v;
        logic signed [15:0] part;
        reg_v = gate_cfg[r * 2 + c / 2];
        part  = reg_v[(c % 2) * 32 + p * 16 +: 16];
        return longint'(part);
    endfunction

    function automatic logic [15:0] rounded_part(input longint acc);
        longint v;
        v = (acc + 8192) >>> 14;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic void sweep_gate(input logic [3:0] site);
        int          hi, lo;
        int          addr [4];
        longint      are [4], aim [4];
        logic [31:0] nw [4];
        longint      sr, si, gr, gi;
        logic signed [15:0] p;
        if (site < QUBITS - 1) begin
            hi = 1 << (QUBITS - 1 - site);
            lo = 1 << (QUBITS - 2 - site);
        end else begin
            hi = 1;
            lo = 1 << (QUBITS - 1);
        end
        for (int n = 0; n < DEPTH; n++) begin
            if ((n & (hi | lo)) != 0) continue;
            addr[0] = n;
            addr[1] = n | lo;
            addr[2] = n | hi;
            addr[3] = n | hi | lo;
            for (int c = 0; c < 4; c++) begin
                p = amp_model[addr[c]][15:0];
                are[c] = p;
                p = amp_model[addr[c]][31:16];
                aim[c] = p;
            end
            for (int r = 0; r < 4; r++) begin
                sr = 0;
                si = 0;
                for (int c = 0; c < 4; c++) begin
                    gr = gate_entry(r, c, 0);
                    gi = gate_entry(r, c, 1);
                    sr += gr * are[c] - gi * aim[c];
                    si += gr * aim[c] + gi * are[c];
                end
                nw[r] = {rounded_part(si), rounded_part(sr)};
            end
            for (int r = 0; r < 4; r++) amp_model[addr[r]] = nw[r];
        end
    endfunction

    function automatic void predict_beat(input logic [1:0] kind, input logic [9:0] index,
                                         input logic [3:0] site, input logic [15:0] re,
                                         input logic [15:0] im);
        t_done d;
        d = '0;
        d.kind = kind;
        case (kind)
            tqg_pkg::KIND_WRITE: begin
                amp_model[index]  = {im, re};
                amp_loaded[index] = 1'b1;
            end
            tqg_pkg::KIND_READ: begin
                d.re = amp_model[index][15:0];
                d.im = amp_model[index][31:16];
            end
            tqg_pkg::KIND_GATE: begin
                sweep_gate(site);
            end
            default: begin
            end
        endcase
        if (kind != KIND_UNUSED) pending_done.push_back(d);
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [9:0] index,
                             input logic [3:0] site, input logic [15:0] re,
                             input logic [15:0] im);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_index    <= index;
        i_site     <= site;
        i_amp_re   <= re;
        i_amp_im   <= im;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        predict_beat(kind, index, site, re, im);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_done.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_gate_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        gate_cfg[idx] = data;
    endtask

    task automatic load_gate(input logic [15:0] part_fill, input bit rand_fill);
        logic [63:0] v;
        logic [15:0] p;
        wait_idle();
        for (int r = 0; r < NUM_GATE_REG; r++) begin
            for (int k = 0; k < 4; k++) begin
                if (!rand_fill) p = part_fill;
                else if ($urandom_range(0, 3) == 0) p = 16'($urandom);
                else p = 16'(int'($urandom_range(0, 16384)) - 8192);
                v[k * 16 +: 16] = p;
            end
            write_gate_reg(3'(r), v);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_identity();
        wait_idle();
        write_gate_reg(REG_ROW0_C01, 64'd16384);
        write_gate_reg(REG_ROW0_C23, 64'd0);
        write_gate_reg(REG_ROW1_C01, 64'd16384 << 32);
        write_gate_reg(REG_ROW1_C23, 64'd0);
        write_gate_reg(REG_ROW2_C01, 64'd0);
        write_gate_reg(REG_ROW2_C23, 64'd16384);
        write_gate_reg(REG_ROW3_C01, 64'd0);
        write_gate_reg(REG_ROW3_C23, 64'd16384 << 32);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [9:0] loaded_index();
        logic [9:0] idx;
        do idx = 10'($urandom_range(0, DEPTH - 1)); while (!amp_loaded[idx]);
        return idx;
    endfunction

    task automatic random_beat(input int gate_pct);
        int          pick;
        logic [15:0] re, im;
        pick = $urandom_range(0, 99);
        re = 16'($urandom);
        im = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            re = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        end
        if (pick < gate_pct) begin
            send_beat(tqg_pkg::KIND_GATE, 10'($urandom), 4'($urandom), re, im);
        end else if (pick < 50) begin
            send_beat(tqg_pkg::KIND_WRITE, 10'($urandom), 4'($urandom), re, im);
        end else if (pick < 95) begin
            send_beat(tqg_pkg::KIND_READ, loaded_index(), 4'($urandom), re, im);
        end else begin
            send_beat(KIND_UNUSED, 10'($urandom), 4'($urandom), re, im);
        end
    endtask

    task automatic test_directed_rw();
        send_beat(tqg_pkg::KIND_WRITE, 10'h000, 4'h0, 16'h8000, 16'h7FFF);
        send_beat(tqg_pkg::KIND_WRITE, 10'h3FF, 4'hF, 16'h7FFF, 16'h8000);
        send_beat(tqg_pkg::KIND_WRITE, 10'h2AA, 4'h5, 16'hFFFF, 16'h0000);
        send_beat(tqg_pkg::KIND_WRITE, 10'h155, 4'hA, 16'h0000, 16'hFFFF);
        send_beat(KIND_UNUSED, 10'h000, 4'h0, 16'h1234, 16'h5678);
        send_beat(tqg_pkg::KIND_READ, 10'h000, 4'h0, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h3FF, 4'h0, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h2AA, 4'h0, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h155, 4'h0, 16'h0, 16'h0);
        send_beat(KIND_UNUSED, 10'h3FF, 4'hF, 16'hFFFF, 16'hFFFF);
        send_beat(tqg_pkg::KIND_READ, 10'h000, 4'h0, 16'h0, 16'h0);
    endtask

    task automatic test_load_vector();
        for (int n = 0; n < DEPTH; n++) begin
            send_beat(tqg_pkg::KIND_WRITE, 10'(n), 4'($urandom), 16'($urandom),
                      16'($urandom));
            if ($urandom_range(0, 15) == 0) begin
                send_beat(tqg_pkg::KIND_READ, loaded_index(), 4'h0, 16'h0, 16'h0);
            end
        end
    endtask

    task automatic test_gate_sites();
        logic [3:0] sites [6] = '{4'd0, 4'd4, 4'd8, 4'd9, 4'd12, 4'd15};
        load_identity();
        foreach (sites[s]) send_beat(tqg_pkg::KIND_GATE, 10'h0, sites[s], 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h001, 4'h0, 16'h0, 16'h0);
        load_gate(16'h7FFF, 1'b0);
        send_beat(tqg_pkg::KIND_GATE, 10'h0, 4'd3, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h200, 4'h0, 16'h0, 16'h0);
        load_gate(16'h8000, 1'b0);
        send_beat(tqg_pkg::KIND_GATE, 10'h0, 4'd9, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h0FF, 4'h0, 16'h0, 16'h0);
        load_gate(16'h0000, 1'b0);
        send_beat(tqg_pkg::KIND_GATE, 10'h0, 4'd1, 16'h0, 16'h0);
        send_beat(tqg_pkg::KIND_READ, 10'h3FF, 4'h0, 16'h0, 16'h0);
    endtask

    task automatic test_random_mix(input int beats);
        for (int n = 0; n < beats; n++) begin
            if (n % 100 == 0) begin
                if ($urandom_range(0, 1) != 0) load_gate(16'h0, 1'b1);
                else load_identity();
                for (int k = 0; k < 64; k++) begin
                    send_beat(tqg_pkg::KIND_WRITE, 10'($urandom), 4'h0, 16'($urandom),
                              16'($urandom));
                end
            end
            random_beat(4);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        rx_hold = 200;
        for (int n = 0; n < 30; n++) random_beat(0);
    endtask

    task automatic test_full_rate();
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int n = 0; n < 60; n++) random_beat(2);
        i_in_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_burst = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_done d;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_done.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d", o_done_kind));
            end else begin
                d = pending_done.pop_front();
                if (o_done_kind !== d.kind)
                    report_mismatch($sformatf("done_kind %0d, want %0d", o_done_kind, d.kind));
                if (o_read_re !== d.re)
                    report_mismatch($sformatf("read_re %h, want %h", o_read_re, d.re));
                if (o_read_im !== d.im)
                    report_mismatch($sformatf("read_im %h, want %h", o_read_im, d.im));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** two_qubit_gate_state_vector_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = tqg_pkg::KIND_WRITE;
        i_index     = '0;
        i_site      = '0;
        i_amp_re    = '0;
        i_amp_im    = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        errors      = 0;
        idle_cycles = 0;
        rx_burst    = 0;
        rx_hold     = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        foreach (amp_loaded[n]) amp_loaded[n] = 1'b0;
        foreach (amp_model[n]) amp_model[n] = '0;
        gate_cfg = '{64'd16384, 64'd0, 64'd16384 << 32, 64'd0,
                     64'd0, 64'd16384, 64'd0, 64'd16384 << 32};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_rw();
        test_load_vector();
        test_gate_sites();
        test_random_mix(500);
        test_backpressure();
        test_full_rate();

        while (pending_done.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("** two_qubit_gate_state_vector_core: PASSED **");
        end else begin
            $display("** two_qubit_gate_state_vector_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: two_qubit_gate_state_vector_core.f
rtl/tqg_pkg.sv
rtl/tqg_cmac.sv
rtl/two_qubit_gate_state_vector_core.sv
sim/testbench.sv
